/* rtl/tob_pkg.sv */
// shared types, widths and codes of the timestamp ordered buffer
`timescale 1ns / 1ps
package tob_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int STAMP_W  = 64;
  localparam int HANDLE_W = 32;
  localparam int ENTRY_W  = STAMP_W + HANDLE_W;
  localparam int ACT_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int LAG_W    = 16;
  localparam int MIN_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int NS_PER_MS = 1000000;
  localparam int NS_W     = 20;
  localparam int LAG_NS_W = LAG_W + NS_W;
  localparam int CMP_W    = ((CNT_W > MIN_W) ? CNT_W : MIN_W) + 1;

  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CONTAINS = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAN    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LAG_ERR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN = 1'b1;

  localparam logic [LAG_W-1:0] LAG_RESET = 16'd0;
  localparam logic [MIN_W-1:0] MIN_RESET = 7'd16;

  typedef struct packed {
    logic lt;
    logic eq;
  } alu_flags_t;

endpackage

/* rtl/tob_ram.sv */
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module tob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tob_alu.sv */
// shared subtract and compare unit for timestamps
`timescale 1ns / 1ps
module tob_alu import tob_pkg::*; (
  input  logic [STAMP_W-1:0] a_i,
  input  logic [STAMP_W-1:0] b_i,
  output logic [STAMP_W-1:0] diff_o,
  output alu_flags_t         flags_o
);

  logic [STAMP_W:0] sub;

  assign sub           = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o        = sub[STAMP_W-1:0];
  assign flags_o.lt    = sub[STAMP_W];
  assign flags_o.eq    = (sub[STAMP_W-1:0] == '0);

endmodule

/* rtl/timestamp_ordered_buffer_unit.sv */
// top level: sorted timestamp table in a circular ram walked by a sequencer
//
//   channel | direction | handshake              | beat
//   in      | input     | in_valid_i/in_ready_o   | action_i, stamp_i, handle_i
//   out     | output    | out_valid_o/out_ready_i | status_o .. newest_stamp_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// each beat walks the states in order: insert moves entries up one slot from the newest down,
// lookup subtracts the lag and then scans from the oldest entry, contains scans from the oldest;
// every action then reads the oldest and newest entries unless the table ends empty
// the single ram read port is shared by the scan, the insert walk and the final reads
// no clearing pass: reset zeroes the count and the head index, the ram keeps its contents
// in_ready_o is high only when idle; a finished beat waits in the output register
`timescale 1ns / 1ps
module timestamp_ordered_buffer_unit import tob_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [STAMP_W-1:0]    stamp_i,
  input  logic [HANDLE_W-1:0]   handle_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  found_o,
  output logic [HANDLE_W-1:0]   item_handle_o,
  output logic [STAMP_W-1:0]    item_stamp_o,
  output logic [COUNT_W-1:0]    count_o,
  output logic [STAMP_W-1:0]    oldest_stamp_o,
  output logic [STAMP_W-1:0]    newest_stamp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_LAG_MUL  = 11'b00000000010,
    S_LAG_SUB  = 11'b00000000100,
    S_SCAN_RD  = 11'b00000001000,
    S_SCAN_CMP = 11'b00000010000,
    S_INS_RD   = 11'b00000100000,
    S_INS_CMP  = 11'b00001000000,
    S_FIN_RD0  = 11'b00010000000,
    S_FIN_RD1  = 11'b00100000000,
    S_FIN_CAP  = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [ACT_W-1:0]    act_q, act_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [STAMP_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [LAG_W-1:0]    lag_q;
  logic [MIN_W-1:0]    min_q;
  logic [LAG_NS_W-1:0] lag_ns_q, lag_ns_d;
  logic [STAMP_W-1:0]  prev_stamp_q, prev_stamp_d;
  logic [HANDLE_W-1:0] prev_handle_q, prev_handle_d;
  logic                have_prev_q, have_prev_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                res_found_q, res_found_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [STAMP_W-1:0]  res_stamp_q, res_stamp_d;
  logic [STAMP_W-1:0]  oldest_q, oldest_d;
  logic [STAMP_W-1:0]  newest_q, newest_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  logic [STATUS_W-1:0] out_status_q;
  logic                out_found_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [STAMP_W-1:0]  out_stamp_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [STAMP_W-1:0]  out_oldest_q;
  logic [STAMP_W-1:0]  out_newest_q;

  logic                we;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [ENTRY_W-1:0]  wdata, rdata;
  logic [STAMP_W-1:0]  ent_stamp;
  logic [HANDLE_W-1:0] ent_handle;

  logic [STAMP_W-1:0]  alu_a, alu_b, alu_diff;
  alu_flags_t          alu_flags;

  logic [CMP_W-1:0]    cnt_ext, min_ext, excess;
  logic                is_lookup;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  tob_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tob_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .diff_o  (alu_diff),
    .flags_o (alu_flags)
  );

  assign ent_stamp  = rdata[ENTRY_W-1:HANDLE_W];
  assign ent_handle = rdata[HANDLE_W-1:0];
  assign is_lookup  = (act_q == ACT_LOOKUP);
  assign cnt_ext    = CMP_W'(count_q);
  assign min_ext    = CMP_W'(min_q);
  assign excess     = cnt_ext - min_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d       = state_q;
    act_d         = act_q;
    stamp_d       = stamp_q;
    handle_d      = handle_q;
    key_d         = key_q;
    k_d           = k_q;
    count_d       = count_q;
    head_d        = head_q;
    lag_ns_d      = lag_ns_q;
    prev_stamp_d  = prev_stamp_q;
    prev_handle_d = prev_handle_q;
    have_prev_d   = have_prev_q;
    res_status_d  = res_status_q;
    res_found_d   = res_found_q;
    res_handle_d  = res_handle_q;
    res_stamp_d   = res_stamp_q;
    oldest_d      = oldest_q;
    newest_d      = newest_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_load      = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    alu_a         = '0;
    alu_b         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d        = action_i;
          stamp_d      = stamp_i;
          handle_d     = handle_i;
          key_d        = stamp_i;
          k_d          = '0;
          have_prev_d  = 1'b0;
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          res_handle_d = '0;
          res_stamp_d  = '0;
          state_d      = S_FIN_RD0;
          unique case (action_i)
            ACT_INSERT: begin
              if (count_q >= CNT_W'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                k_d     = count_q;
                state_d = S_INS_RD;
              end
            end
            ACT_LOOKUP:   state_d = S_LAG_MUL;
            ACT_CONTAINS: state_d = S_SCAN_RD;
            ACT_CLEAN: begin
              if (cnt_ext > min_ext && excess > CMP_W'(1)) begin
                head_d  = phys(head_q, CNT_W'(excess));
                count_d = CNT_W'(min_ext);
              end
            end
            ACT_CLEAR:    count_d = '0;
            default:      state_d = S_FIN_RD0;
          endcase
        end
      end
      S_LAG_MUL: begin
        lag_ns_d = LAG_NS_W'(lag_q) * LAG_NS_W'(NS_PER_MS);
        state_d  = S_LAG_SUB;
      end
      S_LAG_SUB: begin
        alu_a = stamp_q;
        alu_b = STAMP_W'(lag_ns_q);
        if (alu_flags.lt) begin
          res_status_d = ST_LAG_ERR;
          state_d      = S_FIN_RD0;
        end else begin
          key_d   = alu_diff;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (k_q == count_q) begin
          if (is_lookup && have_prev_q) begin
            res_found_d  = 1'b1;
            res_stamp_d  = prev_stamp_q;
            res_handle_d = prev_handle_q;
          end
          state_d = S_FIN_RD0;
        end else begin
          raddr   = phys(head_q, k_q);
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        alu_a = ent_stamp;
        alu_b = key_q;
        if (alu_flags.lt) begin
          prev_stamp_d  = ent_stamp;
          prev_handle_d = ent_handle;
          have_prev_d   = 1'b1;
          k_d           = k_q + CNT_W'(1);
          state_d       = S_SCAN_RD;
        end else begin
          if (alu_flags.eq) begin
            res_found_d = 1'b1;
            if (is_lookup) begin
              res_stamp_d  = ent_stamp;
              res_handle_d = ent_handle;
            end
          end else if (is_lookup && have_prev_q) begin
            res_found_d  = 1'b1;
            res_stamp_d  = prev_stamp_q;
            res_handle_d = prev_handle_q;
          end
          state_d = S_FIN_RD0;
        end
      end
      S_INS_RD: begin
        if (k_q == '0) begin
          we      = 1'b1;
          waddr   = phys(head_q, k_q);
          wdata   = {stamp_q, handle_q};
          count_d = count_q + CNT_W'(1);
          state_d = S_FIN_RD0;
        end else begin
          raddr   = phys(head_q, k_q - CNT_W'(1));
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        alu_a = stamp_q;
        alu_b = ent_stamp;
        we    = 1'b1;
        waddr = phys(head_q, k_q);
        if (alu_flags.lt) begin
          wdata   = rdata;
          k_d     = k_q - CNT_W'(1);
          state_d = S_INS_RD;
        end else begin
          wdata   = {stamp_q, handle_q};
          count_d = count_q + CNT_W'(1);
          state_d = S_FIN_RD0;
        end
      end
      S_FIN_RD0: begin
        if (count_q == '0) begin
          oldest_d = '0;
          newest_d = '0;
          state_d  = S_DONE;
        end else begin
          raddr   = phys(head_q, '0);
          state_d = S_FIN_RD1;
        end
      end
      S_FIN_RD1: begin
        oldest_d = ent_stamp;
        raddr    = phys(head_q, count_q - CNT_W'(1));
        state_d  = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        newest_d = ent_stamp;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      lag_q       <= LAG_RESET;
      min_q       <= MIN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LAG: lag_q <= cfg_data_i[LAG_W-1:0];
          CFG_MIN: min_q <= cfg_data_i[MIN_W-1:0];
          default: lag_q <= lag_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q         <= act_d;
    stamp_q       <= stamp_d;
    handle_q      <= handle_d;
    key_q         <= key_d;
    k_q           <= k_d;
    lag_ns_q      <= lag_ns_d;
    prev_stamp_q  <= prev_stamp_d;
    prev_handle_q <= prev_handle_d;
    have_prev_q   <= have_prev_d;
    res_status_q  <= res_status_d;
    res_found_q   <= res_found_d;
    res_handle_q  <= res_handle_d;
    res_stamp_q   <= res_stamp_d;
    oldest_q      <= oldest_d;
    newest_q      <= newest_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_handle_q <= res_handle_q;
      out_stamp_q  <= res_stamp_q;
      out_count_q  <= COUNT_W'(count_q);
      out_oldest_q <= oldest_q;
      out_newest_q <= newest_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_o        = out_found_q;
  assign item_handle_o  = out_handle_q;
  assign item_stamp_o   = out_stamp_q;
  assign count_o        = out_count_q;
  assign oldest_stamp_o = out_oldest_q;
  assign newest_stamp_o = out_newest_q;

endmodule

/* rtl/tob_checker.sv */
// port level checks of the timestamp ordered buffer, bound to the top level
`timescale 1ns / 1ps
module tob_checker import tob_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_o,
  input logic                found_o,
  input logic [COUNT_W-1:0]  count_o,
  input logic [STAMP_W-1:0]  oldest_stamp_o,
  input logic [STAMP_W-1:0]  newest_stamp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_o) && $stable(status_o))
    else $error("output beat dropped or changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_o == '0 |-> oldest_stamp_o == '0 && newest_stamp_o == '0)
    else $error("empty table reports nonzero bounds");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_o != '0 |-> oldest_stamp_o <= newest_stamp_o)
    else $error("oldest stamp later than newest");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == COUNT_W'(DEPTH) && !found_o)
    else $error("full status with table not full");

  a_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_LAG_ERR |-> !found_o)
    else $error("lag error reported with a hit");

endmodule

bind timestamp_ordered_buffer_unit tob_checker u_tob_checker (.*);

/* tb/testbench.sv */
// testbench for the timestamp ordered buffer: directed and random beats checked against a local table
`timescale 1ns / 1ps
module testbench;
  import tob_pkg::*;

  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [HANDLE_W-1:0] item_handle;
    logic [STAMP_W-1:0]  item_stamp;
    logic [COUNT_W-1:0]  count;
    logic [STAMP_W-1:0]  oldest;
    logic [STAMP_W-1:0]  newest;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ACT_W-1:0]      action = '0;
  logic [STAMP_W-1:0]    stamp = '0;
  logic [HANDLE_W-1:0]   handle = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic                  found;
  logic [HANDLE_W-1:0]   item_handle;
  logic [STAMP_W-1:0]    item_stamp;
  logic [COUNT_W-1:0]    count;
  logic [STAMP_W-1:0]    oldest_stamp;
  logic [STAMP_W-1:0]    newest_stamp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // local copy of the table and registers
  logic [STAMP_W-1:0]  tbl_stamp [DEPTH];
  logic [HANDLE_W-1:0] tbl_handle [DEPTH];
  int                  tbl_count = 0;
  logic [LAG_W-1:0]    lag_ms = LAG_RESET;
  logic [MIN_W-1:0]    min_size = MIN_RESET;

  answer_t             pending_answers [$];
  int                  error_count = 0;
  bit                  idling = 1'b1;
  int                  stall_left = 0;
  logic [STAMP_W-1:0]  stamp_base = '0;
  int unsigned         stamp_span = 50;

  timestamp_ordered_buffer_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .stamp_i        (stamp),
    .handle_i       (handle),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .found_o        (found),
    .item_handle_o  (item_handle),
    .item_stamp_o   (item_stamp),
    .count_o        (count),
    .oldest_stamp_o (oldest_stamp),
    .newest_stamp_o (newest_stamp),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic answer_t update_table(input logic [ACT_W-1:0] act,
                                           input logic [STAMP_W-1:0] st,
                                           input logic [HANDLE_W-1:0] hd);
    answer_t            a;
    int                 pos;
    int                 i;
    int                 excess;
    logic [STAMP_W-1:0] lag_ns;
    logic [STAMP_W-1:0] eff;
    a = '0;
    lag_ns = STAMP_W'(lag_ms) * STAMP_W'(NS_PER_MS);
    case (act)
      ACT_INSERT: begin
        if (tbl_count >= DEPTH) begin
          a.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_stamp[pos] <= st) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_stamp[i] = tbl_stamp[i-1];
            tbl_handle[i] = tbl_handle[i-1];
          end
          tbl_stamp[pos] = st;
          tbl_handle[pos] = hd;
          tbl_count++;
        end
      end
      ACT_LOOKUP: begin
        if (st < lag_ns) begin
          a.status = ST_LAG_ERR;
        end else if (tbl_count > 0) begin
          eff = st - lag_ns;
          pos = 0;
          while (pos < tbl_count && tbl_stamp[pos] < eff) pos++;
          if (pos < tbl_count && tbl_stamp[pos] == eff) begin
            a.found = 1'b1;
          end else if (pos > 0) begin
            pos--;
            a.found = 1'b1;
          end
          if (a.found) begin
            a.item_handle = tbl_handle[pos];
            a.item_stamp = tbl_stamp[pos];
          end
        end
      end
      ACT_CONTAINS: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_stamp[i] == st) a.found = 1'b1;
        end
      end
      ACT_CLEAN: begin
        excess = tbl_count - int'(min_size);
        if (excess > 1) begin
          for (i = excess; i < tbl_count; i++) begin
            tbl_stamp[i-excess] = tbl_stamp[i];
            tbl_handle[i-excess] = tbl_handle[i];
          end
          tbl_count -= excess;
        end
      end
      ACT_CLEAR: begin
        tbl_count = 0;
      end
      default: begin
      end
    endcase
    a.count = COUNT_W'(tbl_count);
    if (tbl_count > 0) begin
      a.oldest = tbl_stamp[0];
      a.newest = tbl_stamp[tbl_count-1];
    end
    return a;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_answer();
    answer_t want;
    if (pending_answers.size() == 0) begin
      $error("result beat with nothing expected");
      error_count++;
    end else begin
      want = pending_answers.pop_front();
      check_field("status", 64'(want.status), 64'(status));
      check_field("found", 64'(want.found), 64'(found));
      check_field("item_handle", 64'(want.item_handle), 64'(item_handle));
      check_field("item_stamp", want.item_stamp, item_stamp);
      check_field("count", 64'(want.count), 64'(count));
      check_field("oldest_stamp", want.oldest, oldest_stamp);
      check_field("newest_stamp", want.newest, newest_stamp);
    end
  endtask

  // result side: check each beat, then draw the stall before the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        check_answer();
        stall_left = idling ? $urandom_range(0, 8) : 0;
      end
      if (stall_left > 0) begin
        if (out_valid) stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [STAMP_W-1:0] st,
                           input logic [HANDLE_W-1:0] hd);
    int gap;
    gap = idling ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    stamp <= st;
    handle <= hd;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(update_table(act, st, hd));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [LAG_W-1:0] lag,
                               input logic [CFG_DATA_W-1:0] min_word);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LAG;
    cfg_data <= lag;
    do @(posedge clk); while (!cfg_ready);
    lag_ms = lag;
    cfg_index <= CFG_MIN;
    cfg_data <= min_word;
    do @(posedge clk); while (!cfg_ready);
    min_size = min_word[MIN_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [STAMP_W-1:0] fresh_stamp();
    if ($urandom_range(0, 19) == 0) return {$urandom, $urandom};
    return stamp_base + STAMP_W'($urandom_range(0, stamp_span));
  endfunction

  // near a stored entry most of the time, one off on either side now and then
  function automatic logic [STAMP_W-1:0] query_stamp(input bit with_lag);
    logic [STAMP_W-1:0] base;
    logic [STAMP_W-1:0] lag_ns;
    lag_ns = STAMP_W'(lag_ms) * STAMP_W'(NS_PER_MS);
    if (tbl_count > 0 && $urandom_range(0, 3) != 0)
      base = tbl_stamp[$urandom_range(0, tbl_count - 1)];
    else
      base = fresh_stamp();
    case ($urandom_range(0, 4))
      0: base = base - 1;
      1: base = base + 1;
      default: begin
      end
    endcase
    if (with_lag && $urandom_range(0, 7) != 0) base = base + lag_ns;
    return base;
  endfunction

  task automatic test_empty_table();
    int k;
    send_item(ACT_LOOKUP, '0, '0);
    send_item(ACT_CONTAINS, STAMP_MAX, '0);
    send_item(ACT_CLEAN, '0, '0);
    send_item(ACT_CLEAR, '0, '0);
    for (k = 1; k <= 3; k++) send_item(ACT_CLEAR + ACT_W'(k), {$urandom, $urandom}, $urandom);
  endtask

  task automatic test_order_and_lookup();
    send_item(ACT_INSERT, 64'd1000, 32'h1);
    send_item(ACT_INSERT, '0, '0);
    send_item(ACT_INSERT, STAMP_MAX, '1);
    send_item(ACT_INSERT, 64'd1000, 32'h2);
    send_item(ACT_LOOKUP, 64'd1000, '0);
    send_item(ACT_LOOKUP, 64'd1500, '0);
    send_item(ACT_LOOKUP, 64'd999, '0);
    send_item(ACT_LOOKUP, STAMP_MAX, '0);
    send_item(ACT_CONTAINS, 64'd1000, '0);
    send_item(ACT_CONTAINS, 64'd1001, '0);
  endtask

  task automatic test_lag();
    set_registers(16'd1, CFG_DATA_W'(MIN_RESET));
    send_item(ACT_LOOKUP, 64'd999_999, '0);
    send_item(ACT_LOOKUP, 64'd1_000_000, '0);
    set_registers('1, CFG_DATA_W'(MIN_RESET));
    send_item(ACT_LOOKUP, STAMP_MAX, '0);
    send_item(ACT_LOOKUP, '0, '0);
    set_registers('0, CFG_DATA_W'(MIN_RESET));
    send_item(ACT_CLEAR, '0, '0);
    send_item(ACT_INSERT, 64'd5000, 32'hA5A5_5A5A);
    send_item(ACT_LOOKUP, 64'd100, '0);
  endtask

  task automatic test_clean();
    set_registers('0, CFG_DATA_W'(1));
    send_item(ACT_INSERT, 64'd10, 32'h10);
    send_item(ACT_CLEAN, '0, '0);
    send_item(ACT_INSERT, 64'd20, 32'h20);
    send_item(ACT_CLEAN, '0, '0);
    set_registers('0, '0);
    send_item(ACT_INSERT, 64'd30, 32'h30);
    send_item(ACT_CLEAN, '0, '0);
    set_registers('0, CFG_DATA_W'(7'h7F));
    send_item(ACT_INSERT, 64'd40, 32'h40);
    send_item(ACT_INSERT, 64'd50, 32'h50);
    send_item(ACT_INSERT, 64'd60, 32'h60);
    send_item(ACT_CLEAN, '0, '0);
  endtask

  task automatic test_random_traffic();
    int               phase;
    int               n;
    int               pick;
    int               insert_pct;
    logic [LAG_W-1:0] lag;
    logic [MIN_W-1:0] min_val;
    logic [ACT_W-1:0] act;
    logic [STAMP_W-1:0] st;
    for (phase = 0; phase < 20; phase++) begin
      case ($urandom_range(0, 3))
        0: lag = '0;
        1: lag = '1;
        2: lag = LAG_W'($urandom_range(1, 20));
        default: lag = LAG_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: min_val = MIN_W'(1);
        1: min_val = MIN_W'(DEPTH);
        2: min_val = MIN_W'($urandom_range(0, 127));
        3: min_val = '0;
        default: min_val = MIN_W'($urandom_range(1, DEPTH));
      endcase
      set_registers(lag, {9'($urandom_range(0, 3) == 0 ? $urandom : 0), min_val});
      idling = (phase % 4 != 3);
      case ($urandom_range(0, 3))
        0: begin
          stamp_base = '0;
          stamp_span = 50;
        end
        1: begin
          stamp_base = {$urandom, $urandom};
          stamp_span = 32'h0010_0000;
        end
        2: begin
          stamp_base = STAMP_MAX - 64'h1_0000;
          stamp_span = 32'h1_0000;
        end
        default: begin
          stamp_base = {$urandom, $urandom};
          stamp_span = 32'h8000_0000;
        end
      endcase
      insert_pct = (phase % 3 == 0) ? 85 : 45;
      for (n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) act = ACT_INSERT;
        else if (pick < insert_pct + (90 - insert_pct) / 2 + 5) act = ACT_LOOKUP;
        else if (pick < 92) act = ACT_CONTAINS;
        else if (pick < 97) act = ACT_CLEAN;
        else if (pick < 99) act = ACT_CLEAR;
        else act = ACT_CLEAR + ACT_W'($urandom_range(1, 3));
        // fill phases turn cleans and clears into inserts so the table keeps growing until it is full
        if (insert_pct > 50 && (act == ACT_CLEAN || act == ACT_CLEAR)) act = ACT_INSERT;
        case (act)
          ACT_INSERT: st = fresh_stamp();
          ACT_LOOKUP: st = query_stamp(1'b1);
          ACT_CONTAINS: st = query_stamp(1'b0);
          default: st = {$urandom, $urandom};
        endcase
        send_item(act, st, $urandom);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_order_and_lookup();
    test_lag();
    test_clean();
    test_random_traffic();
    drain();
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/tob_pkg.sv
rtl/tob_ram.sv
rtl/tob_alu.sv
rtl/timestamp_ordered_buffer_unit.sv
rtl/tob_checker.sv
tb/testbench.sv
